// ----- src/spa_pkg.sv -----
// Shared types, constants and arithmetic helpers of the sparse polynomial accumulator.
package spa_pkg;

  localparam int MAX_TERMS = 64;
  localparam int COEF_W    = 32;
  localparam int EXP_W     = 16;

  localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  // Item kinds on the input channel.
  localparam logic KIND_ACC  = 1'b0;
  localparam logic KIND_READ = 1'b1;

  typedef struct packed {
    logic                     kind;
    logic signed [COEF_W-1:0] coefficient;
    logic signed [EXP_W-1:0]  exponent;
    logic                     negate;
  } in_word_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] out_coefficient;
    logic signed [EXP_W-1:0]  out_exponent;
    logic                     empty_res;
    logic                     overflow;
    logic                     last;
  } out_word_t;

  // One stored term of the polynomial.
  typedef struct packed {
    logic                     valid;
    logic signed [EXP_W-1:0]  exponent;
    logic signed [COEF_W-1:0] coefficient;
  } term_t;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_APPLY = 2'd1,
    CELL_SHIFT = 2'd2
  } cell_op_t;

  // Broadcast control from the chain to every cell.
  typedef struct packed {
    cell_op_t op;
    logic     hit;
    logic     zero;
  } cell_ctrl_t;

  function automatic logic signed [COEF_W-1:0] sat_add(
    input logic signed [COEF_W-1:0] a,
    input logic signed [COEF_W-1:0] b
  );
    logic signed [COEF_W:0] s;
    s = {a[COEF_W-1], a} + {b[COEF_W-1], b};
    if (s[COEF_W] != s[COEF_W-1]) begin
      return s[COEF_W] ? COEF_MIN : COEF_MAX;
    end
    return s[COEF_W-1:0];
  endfunction

  function automatic logic signed [COEF_W-1:0] sat_neg(
    input logic signed [COEF_W-1:0] a
  );
    if (a == COEF_MIN) begin
      return COEF_MAX;
    end
    return -a;
  endfunction

endpackage

// ----- src/spa_cell.sv -----
// One cell of the sorted term chain: holds a single term and updates it from its neighbors.
module spa_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  spa_pkg::cell_ctrl_t ctrl,
  input  spa_pkg::term_t      new_term,
  input  spa_pkg::term_t      left_term,
  input  spa_pkg::term_t      right_term,
  input  logic               left_lt,
  output spa_pkg::term_t      term_q,
  output logic               lt,
  output logic               eq,
  output logic               zero
);
  import spa_pkg::*;

  term_t                    term_r;
  term_t                    term_nxt;
  logic signed [COEF_W-1:0] sum;

  assign term_q = term_r;

  always_comb begin
    lt   = term_r.valid && ($signed(term_r.exponent) < $signed(new_term.exponent));
    eq   = term_r.valid && (term_r.exponent == new_term.exponent);
    sum  = sat_add(term_r.coefficient, new_term.coefficient);
    zero = eq && (sum == '0);

    term_nxt = term_r;
    case (ctrl.op)
      CELL_APPLY: begin
        if (ctrl.hit) begin
          // Merge into the matching term; a zero sum closes the gap from the right.
          if (ctrl.zero) begin
            if (!lt) begin
              term_nxt = right_term;
            end
          end else if (eq) begin
            term_nxt.coefficient = sum;
          end
        end else if (!lt) begin
          // Insertion point takes the new term, everything above moves up by one.
          if (left_lt) begin
            term_nxt = new_term;
          end else begin
            term_nxt = left_term;
          end
        end
      end
      CELL_SHIFT: begin
        term_nxt = right_term;
      end
      default: begin
        term_nxt = term_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      term_r.valid <= 1'b0;
    end else begin
      term_r.valid <= term_nxt.valid;
    end
    term_r.exponent    <= term_nxt.exponent;
    term_r.coefficient <= term_nxt.coefficient;
  end

endmodule

// ----- src/spa_chain.sv -----
// Row of term cells with the broadcast match and zero-sum detection.
module spa_chain (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           req_apply,
  input  logic           req_shift,
  input  spa_pkg::term_t  new_term,
  output spa_pkg::term_t  head_term,
  output logic           second_valid,
  output logic           full,
  output logic           overflow_evt
);
  import spa_pkg::*;

  term_t                term_v [MAX_TERMS];
  logic [MAX_TERMS-1:0] lt_v;
  logic [MAX_TERMS-1:0] eq_v;
  logic [MAX_TERMS-1:0] zero_v;
  logic [MAX_TERMS-1:0] valid_v;
  cell_ctrl_t           ctrl;

  always_comb begin
    ctrl.hit  = |eq_v;
    ctrl.zero = |zero_v;
    if (req_shift) begin
      ctrl.op = CELL_SHIFT;
    end else if (req_apply && (ctrl.hit || !full)) begin
      ctrl.op = CELL_APPLY;
    end else begin
      ctrl.op = CELL_HOLD;
    end
  end

  assign full         = term_v[MAX_TERMS-1].valid;
  assign overflow_evt = req_apply && !ctrl.hit && full;
  assign head_term    = term_v[0];
  assign second_valid = term_v[1].valid;

  for (genvar i = 0; i < MAX_TERMS; i++) begin : g_cell
    term_t left_term;
    term_t right_term;
    logic  left_lt;

    assign valid_v[i] = term_v[i].valid;

    if (i == 0) begin : g_first
      assign left_term = '0;
      assign left_lt   = 1'b1;
    end else begin : g_mid
      assign left_term = term_v[i-1];
      assign left_lt   = lt_v[i-1];
    end

    if (i == MAX_TERMS - 1) begin : g_last
      assign right_term = '0;
    end else begin : g_inner
      assign right_term = term_v[i+1];
    end

    spa_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctrl       (ctrl),
      .new_term   (new_term),
      .left_term  (left_term),
      .right_term (right_term),
      .left_lt    (left_lt),
      .term_q     (term_v[i]),
      .lt         (lt_v[i]),
      .eq         (eq_v[i]),
      .zero       (zero_v[i])
    );
  end

  // Stored terms always form an unbroken run starting at cell zero.
  a_valid_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_v >> 1) & ~valid_v) == '0)
    else $error("term chain has a hole");

  // A sum of zero can only come from a cell that matched the exponent.
  a_zero_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    ctrl.zero |-> ctrl.hit)
    else $error("zero sum without exponent match");

  // Neighboring stored terms are strictly ascending in exponent.
  for (genvar j = 0; j < MAX_TERMS - 1; j++) begin : g_order_chk
    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
      term_v[j+1].valid |-> ($signed(term_v[j].exponent) < $signed(term_v[j+1].exponent)))
      else $error("term chain out of order");
  end

endmodule

// ----- src/sparse_polynomial_accumulator_unit.sv -----
// Top level of the sparse polynomial accumulator.
//
// Usage: words on the input channel (in_valid / in_stall / in_word) are either
// accumulate words, which add a signed coefficient (optionally negated, with
// saturation) to the term of the same exponent, or readout words, which stream
// every stored term in ascending exponent order and then clear the polynomial.
// Accumulate words produce no output. A readout of an empty polynomial yields a
// single word with empty_res and last set. Every readout word carries the
// sticky overflow flag, which is cleared together with the table.
//
// Timing: an accepted word is held in an entry register and is applied to the
// cell chain in the next cycle, so accumulate words are taken at one per cycle
// while no readout holds in_stall high. Each cell compares, adds and moves a
// term combinationally into its own register. A readout word passes through
// the entry register and then loads its results into the output register, one
// per cycle while the output is free, so N terms yield max(N,1) words; in_stall
// stays high until the last result has entered the output register.
//
// Reset (synchronous, rst_n low) empties the polynomial, clears the overflow
// flag and drops any pending word. With out_valid and out_stall both high, the
// output register holds its word and the chain does not advance the readout.
module sparse_polynomial_accumulator_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  spa_pkg::in_word_t  in_word,
  output logic               out_valid,
  input  logic               out_stall,
  output spa_pkg::out_word_t out_word
);
  import spa_pkg::*;

  // Entry register: the word waiting to act on the chain.
  logic     pv_r, pv_nxt;
  in_word_t p_word_r;
  in_word_t p_word_nxt;

  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;
  out_word_t out_word_nxt;

  logic ovf_r, ovf_nxt;

  logic  accept;
  logic  keep_word;
  logic  readout;
  logic  out_free;
  logic  req_apply;
  logic  req_shift;
  logic  finish;
  term_t new_term;
  term_t head_term;
  logic  second_valid;
  logic  full;
  logic  overflow_evt;

  assign readout   = pv_r && (p_word_r.kind == KIND_READ);
  assign in_stall  = readout;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign req_apply = pv_r && (p_word_r.kind == KIND_ACC);
  assign req_shift = readout && out_free && head_term.valid;
  assign finish    = readout && out_free && (!head_term.valid || !second_valid);

  // A zero coefficient changes nothing, so it never becomes a valid entry word.
  assign keep_word = (in_word.kind == KIND_READ) || (in_word.coefficient != '0);

  // The term offered to the chain: always marked valid.
  assign new_term = {1'b1, p_word_r.exponent, p_word_r.coefficient};

  spa_chain u_chain (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_apply    (req_apply),
    .req_shift    (req_shift),
    .new_term     (new_term),
    .head_term    (head_term),
    .second_valid (second_valid),
    .full         (full),
    .overflow_evt (overflow_evt)
  );

  always_comb begin
    // Entry register: negation is resolved on the way in.
    p_word_nxt = p_word_r;
    if (accept) begin
      p_word_nxt = in_word;
      if (in_word.negate) begin
        p_word_nxt.coefficient = sat_neg(in_word.coefficient);
      end
    end
    if (readout) begin
      pv_nxt = !finish;
    end else begin
      pv_nxt = accept && keep_word;
    end

    // Overflow is sticky until a readout completes.
    ovf_nxt = ovf_r;
    if (overflow_evt) begin
      ovf_nxt = 1'b1;
    end else if (finish) begin
      ovf_nxt = 1'b0;
    end

    // Output register: loaded by the readout, drained by the receiver.
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (readout && out_free) begin
      out_valid_nxt = 1'b1;
      out_word_nxt.overflow = ovf_r;
      if (head_term.valid) begin
        out_word_nxt.out_coefficient = head_term.coefficient;
        out_word_nxt.out_exponent    = head_term.exponent;
        out_word_nxt.empty_res       = 1'b0;
        out_word_nxt.last            = !second_valid;
      end else begin
        out_word_nxt.out_coefficient = '0;
        out_word_nxt.out_exponent    = '0;
        out_word_nxt.empty_res       = 1'b1;
        out_word_nxt.last            = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r        <= 1'b0;
      out_valid_r <= 1'b0;
      ovf_r       <= 1'b0;
    end else begin
      pv_r        <= pv_nxt;
      out_valid_r <= out_valid_nxt;
      ovf_r       <= ovf_nxt;
    end
    p_word_r   <= p_word_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // An empty-polynomial word is always the only, and therefore last, word.
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.empty_res) |-> out_word_r.last)
    else $error("empty result not marked last");

  // The overflow flag only rises after a new term was dropped on a full table.
  a_ovf_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(ovf_r) |-> $past(overflow_evt && full))
    else $error("overflow set without a dropped term");

  // Terms never get applied while a readout drains the chain.
  a_no_apply_in_readout: assert property (@(posedge clk) disable iff (!rst_n)
    readout |-> !req_apply && !overflow_evt)
    else $error("term applied during readout");

endmodule
